[rtl/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants, types and sequencer states of the servo packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

  // frame buffer depth and derived widths
  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int POS_W  = 6;
  // length byte plus bias needs one extra bit
  localparam int LEN_W  = BYTE_W + 1;

  // frame layout
  localparam int LEN_AT   = 3;  // index of the length byte
  localparam int LEN_BIAS = 4;  // total length = length byte + bias
  localparam int CK_FIRST = 2;  // checksum covers id up to byte before checksum

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hFF;

  // request codes
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_SUM_LAST,
    S_CHECK,
    S_EMIT,
    S_EMIT_LOAD
  } state_t;

  // control of the checksum unit
  typedef struct packed {
    logic clear;
    logic add;
  } ck_ctl_t;

endpackage

`default_nettype wire

[rtl/spr_in_if.sv]
// ----------------------------------------------------------------------------
// spr_in_if
// Receive channel: serial bytes and restart requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface spr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [spr_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/spr_out_if.sv]
// ----------------------------------------------------------------------------
// spr_out_if
// Frame channel: bytes of verified frames.
// ----------------------------------------------------------------------------
`default_nettype none

interface spr_out_if;
  logic                        valid;
  logic                        ready;
  logic [spr_pkg::BYTE_W-1:0]  frame_byte;
  logic [spr_pkg::POS_W-1:0]   frame_pos;
  logic                        last;

  modport source (output valid, output frame_byte, output frame_pos, output last,
                  input ready);
  modport sink   (input valid, input frame_byte, input frame_pos, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/spr_cfg_if.sv]
// ----------------------------------------------------------------------------
// spr_cfg_if
// Configuration write channel for the header value register.
// ----------------------------------------------------------------------------
`default_nettype none

interface spr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [spr_pkg::BYTE_W-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/servo_packet_receiver.sv]
// ----------------------------------------------------------------------------
// servo_packet_receiver
// Deframes received serial bytes into verified servo protocol frames.
//
// rx carries requests: func 0 is a received byte, func 1 restarts the hunt
// (timeout or new receive). The block hunts for two header bytes equal to the
// header value register, stores the frame in a 64-byte RAM and takes the
// total length from the fourth byte plus four. cfg writes the header value
// (reset 0xFF); it is always ready, to be written only while idle; the block
// does not enforce this. A byte not ending a frame leaves the block idle.
// After the byte that ends a frame of L bytes, a sweep over the RAM read port
// adds the checksum bytes, one per cycle, then compares; the frame goes out
// on frame, each byte read from RAM and then loaded into the output register,
// headers included, last set on the checksum byte. rx is not ready during
// sweep and emission. The output register lets rx take new bytes while the
// last byte of a frame waits; a stall on frame holds the byte and pauses
// emission. Bad checksums and overflows drop the frame silently. Reset clears
// the hunt state and the output valid; the RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_packet_receiver (
  input  wire logic   clk,
  input  wire logic   rst,
  spr_in_if.sink      rx,
  spr_out_if.source   frame,
  spr_cfg_if.sink     cfg
);

  localparam int ADDR_W = spr_pkg::ADDR_W;
  localparam int BYTE_W = spr_pkg::BYTE_W;
  localparam int LEN_W  = spr_pkg::LEN_W;
  localparam int POS_W  = spr_pkg::POS_W;

  spr_pkg::state_t   state, state_next;
  logic [BYTE_W-1:0] header_value;

  // hunt state
  spr_pkg::addr_t    fill, fill_next;
  logic [LEN_W-1:0]  frame_len, frame_len_next;

  // sweep state
  spr_pkg::addr_t    addr, addr_next;
  spr_pkg::addr_t    last_idx, last_idx_next;
  logic [BYTE_W-1:0] ck, ck_next;
  logic              pend, pend_next;

  // output register
  logic              out_valid, out_valid_next;
  logic [BYTE_W-1:0] out_byte, out_byte_next;
  logic [POS_W-1:0]  out_pos, out_pos_next;
  logic              out_last, out_last_next;

  // RAM and checksum unit
  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  spr_pkg::ck_ctl_t  ck_ctl;
  logic              ck_match;

  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  fill_inc;
  logic              complete;
  logic              overflow;

  spr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (spr_pkg::FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill),
    .wdata (rx.rx_byte),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  spr_cksum u_cksum (
    .clk   (clk),
    .ctl   (ck_ctl),
    .data  (ram_rdata),
    .ck    (ck),
    .match (ck_match)
  );

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= spr_pkg::HEADER_RESET;
    end else if (cfg.valid) begin
      header_value <= cfg.data;
    end
  end

  // length known from the byte arriving at the length position
  assign eff_len  = (fill == spr_pkg::addr_t'(spr_pkg::LEN_AT))
                  ? LEN_W'(rx.rx_byte) + LEN_W'(spr_pkg::LEN_BIAS)
                  : frame_len;
  assign fill_inc = LEN_W'(fill) + LEN_W'(1);
  assign complete = (eff_len != '0) && (fill_inc == eff_len);
  assign overflow = (fill_inc == LEN_W'(spr_pkg::FRAME_BYTES));

  assign rx.ready        = (state == spr_pkg::S_IDLE);
  assign frame.valid     = out_valid;
  assign frame.frame_byte = out_byte;
  assign frame.frame_pos = out_pos;
  assign frame.last      = out_last;

  // next state and outputs
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    frame_len_next = frame_len;
    addr_next      = addr;
    last_idx_next  = last_idx;
    ck_next        = ck;
    pend_next      = pend;
    out_valid_next = out_valid;
    out_byte_next  = out_byte;
    out_pos_next   = out_pos;
    out_last_next  = out_last;
    ram_we         = 1'b0;
    ck_ctl         = '0;

    // output taken
    if (out_valid && frame.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      spr_pkg::S_IDLE: begin
        if (rx.valid) begin
          if (rx.func == spr_pkg::FUNC_RESTART) begin
            fill_next      = '0;
            frame_len_next = '0;
          end else if (fill == '0 && rx.rx_byte != header_value) begin
            // still hunting for the first header
            fill_next = '0;
          end else if (fill == spr_pkg::addr_t'(1) && rx.rx_byte != header_value) begin
            fill_next      = '0;
            frame_len_next = '0;
          end else begin
            ram_we = 1'b1;
            if (fill == spr_pkg::addr_t'(spr_pkg::LEN_AT)) begin
              frame_len_next = eff_len;
            end
            if (complete) begin
              // frame in: start the checksum sweep
              last_idx_next  = ADDR_W'(eff_len - LEN_W'(1));
              ck_next        = rx.rx_byte;
              addr_next      = spr_pkg::addr_t'(spr_pkg::CK_FIRST);
              pend_next      = 1'b0;
              ck_ctl.clear   = 1'b1;
              fill_next      = '0;
              frame_len_next = '0;
              state_next     = spr_pkg::S_SUM;
            end else if (overflow) begin
              fill_next      = '0;
              frame_len_next = '0;
            end else begin
              fill_next = fill + spr_pkg::addr_t'(1);
            end
          end
        end
      end

      spr_pkg::S_SUM: begin
        ck_ctl.add = pend;
        pend_next  = 1'b1;
        if (addr == last_idx - spr_pkg::addr_t'(1)) begin
          state_next = spr_pkg::S_SUM_LAST;
        end else begin
          addr_next = addr + spr_pkg::addr_t'(1);
        end
      end

      spr_pkg::S_SUM_LAST: begin
        ck_ctl.add = 1'b1;
        state_next = spr_pkg::S_CHECK;
      end

      spr_pkg::S_CHECK: begin
        if (ck_match) begin
          addr_next  = '0;
          state_next = spr_pkg::S_EMIT;
        end else begin
          state_next = spr_pkg::S_IDLE;
        end
      end

      spr_pkg::S_EMIT: begin
        // read issued, data next cycle
        state_next = spr_pkg::S_EMIT_LOAD;
      end

      spr_pkg::S_EMIT_LOAD: begin
        if (!out_valid || frame.ready) begin
          out_valid_next = 1'b1;
          out_byte_next  = ram_rdata;
          out_pos_next   = POS_W'(addr);
          out_last_next  = (addr == last_idx);
          if (addr == last_idx) begin
            state_next = spr_pkg::S_IDLE;
          end else begin
            addr_next  = addr + spr_pkg::addr_t'(1);
            state_next = spr_pkg::S_EMIT;
          end
        end
      end

      default: begin
        state_next = spr_pkg::S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      frame_len <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      fill      <= fill_next;
      frame_len <= frame_len_next;
      out_valid <= out_valid_next;
      pend      <= pend_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr     <= addr_next;
    last_idx <= last_idx_next;
    ck       <= ck_next;
    out_byte <= out_byte_next;
    out_pos  <= out_pos_next;
    out_last <= out_last_next;
  end

  // a frame byte only appears from the emit load step
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == spr_pkg::S_EMIT_LOAD)
    else $error("frame byte appeared outside emission");

  // while a non-final byte is pending the sequencer stays in emission
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |->
      (state == spr_pkg::S_EMIT || state == spr_pkg::S_EMIT_LOAD))
    else $error("sequencer left emission before the last byte");

  // the checksum sweep stays below the checksum byte
  a_sweep_range: assert property (@(posedge clk) disable iff (rst)
    (state == spr_pkg::S_SUM) |-> (addr < last_idx))
    else $error("checksum sweep ran past the checksum byte");

  // compare only follows the final accumulate
  a_check_order: assert property (@(posedge clk) disable iff (rst)
    (state == spr_pkg::S_CHECK) |-> $past(state) == spr_pkg::S_SUM_LAST)
    else $error("checksum compared before the sweep finished");

endmodule

`default_nettype wire

[rtl/spr_ram.sv]
// ----------------------------------------------------------------------------
// spr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/spr_cksum.sv]
// ----------------------------------------------------------------------------
// spr_cksum
// Checksum unit: 8-bit accumulator and inverted-sum compare.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_cksum (
  input  wire logic                       clk,
  input  wire spr_pkg::ck_ctl_t           ctl,
  input  wire logic [spr_pkg::BYTE_W-1:0] data,
  input  wire logic [spr_pkg::BYTE_W-1:0] ck,
  output logic                            match
);

  logic [spr_pkg::BYTE_W-1:0] acc;

  // running modulo-256 sum
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (ctl.add) begin
      acc <= acc + data;
    end
  end

  // checksum byte is the inverted sum
  assign match = ((~acc) == ck);

endmodule

`default_nettype wire

[bench/servo_packet_receiver_tb.sv]
// ----------------------------------------------------------------------------
// servo_packet_receiver_tb
// Self-checking bench for the servo packet receiver. Feeds it serial bytes and
// restart requests, both well-formed frames with random content and broken or
// noisy sequences. A local deframer predicts the verified frame bytes, and
// each byte leaving the block is compared with the oldest prediction. Random
// gaps stall both channels, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module servo_packet_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_W      = spr_pkg::BYTE_W;
  localparam int POS_W       = spr_pkg::POS_W;
  localparam int FRAME_BYTES = spr_pkg::FRAME_BYTES;
  localparam int LEN_AT      = spr_pkg::LEN_AT;
  localparam int LEN_BIAS    = spr_pkg::LEN_BIAS;
  localparam int CK_FIRST    = spr_pkg::CK_FIRST;

  // settle time after the last expected byte: checksum sweep plus emission
  localparam int SETTLE_CYCLES   = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int unsigned FULL_FRAME = 1000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_beat_t;

  logic clk = 1'b0;
  logic rst;

  spr_in_if  rx ();
  spr_out_if frame ();
  spr_cfg_if cfg ();

  servo_packet_receiver uut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .frame (frame),
    .cfg   (cfg)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // deframer state as the bench sees it
  logic [BYTE_W-1:0] header_reg = spr_pkg::HEADER_RESET;
  logic [BYTE_W-1:0] rx_store [FRAME_BYTES];
  int unsigned       fill_cnt  = 0;
  int unsigned       frame_len = 0;

  frame_beat_t pending_frame_bytes[$];

  logic [BYTE_W-1:0] cur_header = spr_pkg::HEADER_RESET;
  bit                failed        = 1'b0;
  bit                calm          = 1'b1;
  bit                hold_off_req  = 1'b0;
  int unsigned       items_sent    = 0;

  function automatic void clear_hunt();
    fill_cnt  = 0;
    frame_len = 0;
  endfunction

  // predict the frame bytes released by one accepted request
  function automatic void deframe_request(input logic func, input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] ck;
    int unsigned       i;
    frame_beat_t       beat;
    if (func == spr_pkg::FUNC_RESTART) begin
      clear_hunt();
      return;
    end
    if (fill_cnt == 0 && b != header_reg)
      return;
    // a wrong second byte is dropped, not taken as a new first header
    if (fill_cnt == 1 && b != header_reg) begin
      clear_hunt();
      return;
    end
    if (fill_cnt < FRAME_BYTES)
      rx_store[fill_cnt] = b;
    fill_cnt++;
    if (fill_cnt == LEN_AT + 1)
      frame_len = rx_store[LEN_AT] + LEN_BIAS;
    // frame complete: inverted sum from the id up to the byte before the checksum
    if (frame_len > 0 && fill_cnt >= frame_len) begin
      sum = '0;
      for (i = CK_FIRST; i < frame_len - 1; i++)
        if (i < FRAME_BYTES)
          sum += rx_store[i];
      ck = (frame_len - 1 < FRAME_BYTES) ? rx_store[frame_len - 1] : '0;
      if (BYTE_W'(~sum) == ck) begin
        for (i = 0; i < frame_len && i < FRAME_BYTES; i++) begin
          beat.data = rx_store[i];
          beat.pos  = POS_W'(i);
          beat.last = (i == frame_len - 1);
          pending_frame_bytes.push_back(beat);
        end
      end
      clear_hunt();
    end
    // buffer full without a complete frame
    if (fill_cnt >= FRAME_BYTES)
      clear_hunt();
  endfunction

  // idle lengths: mostly short, a few long
  function automatic int idle_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    else if (r < 88)
      return $urandom_range(3, 1);
    else if (r < 97)
      return $urandom_range(12, 4);
    else
      return $urandom_range(80, 20);
  endfunction

  // frame length byte: mostly short frames, few long, rare overflow
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65)
      return $urandom_range(6, 0);
    else if (r < 93)
      return $urandom_range(24, 7);
    else if (r < 98)
      return $urandom_range(60, 25);
    else
      return $urandom_range(70, 61);
  endfunction

  // check delivered bytes, then track config writes and accepted requests
  always @(posedge clk) begin : frame_checker
    frame_beat_t want;
    if (!rst) begin
      if (frame.valid && frame.ready) begin
        if (pending_frame_bytes.size() == 0) begin
          $error("frame_byte %0h at frame_pos %0d with no frame byte expected",
                 frame.frame_byte, frame.frame_pos);
          failed = 1'b1;
        end else begin
          want = pending_frame_bytes.pop_front();
          if (frame.frame_byte !== want.data) begin
            $error("frame_byte: expected %0h, got %0h", want.data, frame.frame_byte);
            failed = 1'b1;
          end
          if (frame.frame_pos !== want.pos) begin
            $error("frame_pos: expected %0d, got %0d", want.pos, frame.frame_pos);
            failed = 1'b1;
          end
          if (frame.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, frame.last);
            failed = 1'b1;
          end
        end
      end
      if (cfg.valid && cfg.ready)
        header_reg = cfg.data;
      if (rx.valid && rx.ready)
        deframe_request(rx.func, rx.rx_byte);
    end
  end

  // frame ready: random stalls, plus one long hold-off on request
  initial begin : frame_ready_driver
    int stall_left;
    stall_left = 0;
    frame.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        frame.ready <= 1'b0;
        stall_left--;
      end else begin
        frame.ready <= 1'b1;
        if (!calm)
          stall_left = idle_gap();
      end
    end
  end

  // send one request, with a random gap ahead of it
  task automatic send_request(input logic func, input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : idle_gap();
    @(negedge clk);
    if (gap > 0) begin
      rx.valid   <= 1'b0;
      rx.func    <= 1'($urandom);
      rx.rx_byte <= BYTE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.func    <= func;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    items_sent++;
  endtask

  // build a frame under the current header; cut short means a restart follows
  task automatic send_frame(input int unsigned len, input logic [BYTE_W-1:0] id,
                            input bit good, input int unsigned cut);
    logic [BYTE_W-1:0] pkt[$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] param;
    int unsigned       k;
    pkt = {cur_header, cur_header, id, BYTE_W'(len)};
    if (len == 0) begin
      // the length byte doubles as checksum: only id 0xff passes
      pkt[2] = good ? 8'hFF : ((id == 8'hFF) ? 8'h00 : id);
    end else begin
      sum = id + BYTE_W'(len);
      for (k = 1; k < len; k++) begin
        param = BYTE_W'($urandom);
        pkt.push_back(param);
        sum += param;
      end
      if (!good)
        sum = sum ^ BYTE_W'($urandom_range(255, 1));
      pkt.push_back(~sum);
    end
    for (k = 0; k < pkt.size() && k < cut; k++)
      send_request(spr_pkg::FUNC_BYTE, pkt[k]);
    if (cut < pkt.size())
      send_request(spr_pkg::FUNC_RESTART, BYTE_W'($urandom));
  endtask

  // drop valid and wait for every predicted byte
  task automatic wait_drained();
    @(negedge clk);
    rx.valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
  endtask

  // header write only once the block has gone quiet
  task automatic write_header(input logic [BYTE_W-1:0] value);
    send_request(spr_pkg::FUNC_RESTART, BYTE_W'($urandom));
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cur_header = value;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // hunt corner cases under the reset header value
  task automatic test_hunt_cases();
    calm = 1'b1;
    write_header(spr_pkg::HEADER_RESET);
    // first byte not a header
    send_request(spr_pkg::FUNC_BYTE, 8'h00);
    // second byte not a header
    send_request(spr_pkg::FUNC_BYTE, cur_header);
    send_request(spr_pkg::FUNC_BYTE, 8'h00);
    // restart in the middle of a frame
    send_request(spr_pkg::FUNC_BYTE, cur_header);
    send_request(spr_pkg::FUNC_BYTE, cur_header);
    send_request(spr_pkg::FUNC_BYTE, 8'h12);
    send_request(spr_pkg::FUNC_RESTART, 8'hFF);
    // zero length byte, four-byte frame
    send_frame(0, 8'hFF, 1'b1, FULL_FRAME);
    // three header bytes in a row, the third is the id
    send_frame(1, cur_header, 1'b1, FULL_FRAME);
    // bad checksum, then a good frame right after
    send_frame(2, 8'h00, 1'b0, FULL_FRAME);
    send_frame(1, 8'hA5, 1'b1, FULL_FRAME);
    wait_drained();
  endtask

  // largest frame and overflowing lengths
  task automatic test_long_frames();
    calm = 1'b0;
    send_frame(FRAME_BYTES - LEN_BIAS, BYTE_W'($urandom), 1'b1, FULL_FRAME);
    send_frame(FRAME_BYTES - LEN_BIAS + 1, BYTE_W'($urandom), 1'b1, FULL_FRAME);
    send_frame(255, BYTE_W'($urandom), 1'b1, 70);
    send_frame(3, BYTE_W'($urandom), 1'b1, FULL_FRAME);
    wait_drained();
  endtask

  // mostly well-formed frames, plus noise and broken sequences
  task automatic test_random_traffic(input logic [BYTE_W-1:0] header, input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned n;
    int unsigned k;
    write_header(header);
    calm = 1'b0;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 72) begin
        send_frame(pick_length(), BYTE_W'($urandom), $urandom_range(99) < 85, FULL_FRAME);
      end else if (r < 82) begin
        // line noise
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++)
          send_request(spr_pkg::FUNC_BYTE, BYTE_W'($urandom));
      end else if (r < 92) begin
        // frame cut short by a timeout
        send_frame(pick_length(), BYTE_W'($urandom), 1'b1, $urandom_range(6, 1));
      end else if (r < 96) begin
        send_request(spr_pkg::FUNC_BYTE, cur_header);
        send_request(spr_pkg::FUNC_BYTE, ~cur_header);
      end else begin
        send_request(spr_pkg::FUNC_RESTART, BYTE_W'($urandom));
      end
    end
    wait_drained();
  endtask

  // receiver holds off while frames keep coming, then sender waits per frame
  task automatic test_backpressure();
    int unsigned k;
    write_header(8'h5A);
    calm = 1'b1;
    hold_off_req = 1'b1;
    for (k = 0; k < 4; k++)
      send_frame($urandom_range(10, 2), BYTE_W'($urandom), 1'b1, FULL_FRAME);
    wait_drained();
    calm = 1'b0;
    for (k = 0; k < 3; k++) begin
      send_frame($urandom_range(8, 0), BYTE_W'($urandom), 1'b1, FULL_FRAME);
      wait_drained();
    end
  endtask

  initial begin : stimulus
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.func    = spr_pkg::FUNC_BYTE;
    rx.rx_byte = '0;
    cfg.valid  = 1'b0;
    cfg.data   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_hunt_cases();
    test_long_frames();
    test_random_traffic(8'h00, 40);
    test_random_traffic(BYTE_W'($urandom), 40);
    test_backpressure();
    test_random_traffic(8'hFF, 40);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failed || pending_frame_bytes.size() != 0)
      $display("servo_packet_receiver_tb failed");
    else
      $display("servo_packet_receiver_tb passed");
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("servo_packet_receiver_tb failed");
    $finish;
  end

endmodule

[files.f]
rtl/spr_pkg.sv
rtl/spr_in_if.sv
rtl/spr_out_if.sv
rtl/spr_cfg_if.sv
rtl/spr_ram.sv
rtl/spr_cksum.sv
rtl/servo_packet_receiver.sv
bench/servo_packet_receiver_tb.sv
